/* rtl/bbs_pkg.sv */
`default_nettype none
package bbs_pkg;

    localparam int PIX_W       = 24;
    localparam int CHAN_W      = 8;
    localparam int CFG_W       = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV9_MUL    = 57;
    localparam int DIV9_SHIFT  = 9;
    localparam int CHAN_MAX    = 255;
    localparam int RESET_WIDTH = 512;
    localparam int MIN_WIDTH   = 3;

    // per-transaction control carried from the front to the back
    typedef struct packed {
        logic q_act;     // blur stream is running for this transaction
        logic q_border;  // blur center lies on the frame border
        logic p_out;     // transaction yields a result
        logic p_border;  // result pixel lies on the frame border
        logic last;      // result is the final pixel of the frame
    } bbs_ctl_t;

    localparam int OUT_W = 2 * PIX_W + 1;

    // floor(v / 9) for 8-bit v by reciprocal multiply
    function automatic logic [4:0] div9(input logic [CHAN_W-1:0] v);
        logic [13:0] prod;
        prod = 14'(v) * 14'(DIV9_MUL);
        return prod[13:DIV9_SHIFT];
    endfunction

endpackage
`default_nettype wire

/* rtl/bbs_fifo.sv */
`default_nettype none
module bbs_fifo
    import bbs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             rd,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    rp_reg, rp_next;
    logic [AW:0]      cnt_reg, cnt_next;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (rd)
        begin
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

/* rtl/bbs_line_ram.sv */
`default_nettype none
module bbs_line_ram
    import bbs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int WIDTH = 24
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // read the old entry, then replace it
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata     <= mem[addr];
            mem[addr] <= wdata;
        end
    end

endmodule
`default_nettype wire

/* rtl/bbs_front.sv */
`default_nettype none
module bbs_front
    import bbs_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              push,
    input  wire logic              kind,
    input  wire logic [PIX_W-1:0]  pix_in,
    input  wire logic              q_full,
    output logic                   q_push,
    output bbs_ctl_t               q_ctl,
    output logic      [PIX_W-1:0]  q_pix,
    output logic      [CW-1:0]     q_tc,
    output logic      [CW-1:0]     q_qc
);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_WIDTH + 3);

    function automatic logic [WW-1:0] clamp_width(input logic [CFG_W-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'(MIN_WIDTH))
        begin
            x = 32'(MIN_WIDTH);
        end
        else if (x > 32'(MAX_WIDTH))
        begin
            x = 32'(MAX_WIDTH);
        end
        return WW'(x);
    endfunction

    logic [WW-1:0] w_reg;
    logic [RW-1:0] tr_reg, tr_next, qr_reg, qr_next, pr_reg, pr_next;
    logic [CW-1:0] tc_reg, tc_next, qc_reg, qc_next, pc_reg, pc_next;
    logic          qa_reg, qa_next, pa_reg, pa_next;

    logic [WW-1:0] wm1;
    logic [CW-1:0] wm1_c;
    logic [RW-1:0] wm1_r;
    logic          accept, q_now, p_now, wrap;

    assign wm1    = w_reg - 1'b1;
    assign wm1_c  = CW'(wm1);
    assign wm1_r  = RW'(wm1);
    assign accept = push && !q_full;
    assign q_now  = qa_reg || (tr_reg == RW'(1) && tc_reg == CW'(1));
    assign p_now  = pa_reg || (tr_reg == RW'(2) && tc_reg == CW'(2));
    assign wrap   = p_now && (pr_reg == wm1_r) && (pc_reg == wm1_c);

    always_comb
    begin
        q_push         = accept;
        q_pix          = kind ? '0 : pix_in;
        q_tc           = tc_reg;
        q_qc           = qc_reg;
        q_ctl.q_act    = q_now;
        q_ctl.q_border = (qr_reg == '0) || (qc_reg == '0) || (qr_reg == wm1_r)
                         || (qc_reg == wm1_c);
        q_ctl.p_out    = p_now;
        q_ctl.p_border = (pr_reg == '0) || (pc_reg == '0) || (pr_reg == wm1_r)
                         || (pc_reg == wm1_c);
        q_ctl.last     = wrap;
    end

    always_comb
    begin
        tr_next = tr_reg;
        tc_next = tc_reg;
        qr_next = qr_reg;
        qc_next = qc_reg;
        pr_next = pr_reg;
        pc_next = pc_reg;
        qa_next = qa_reg;
        pa_next = pa_reg;
        if (cfg_write || (accept && wrap))
        begin
            tr_next = '0;
            tc_next = '0;
            qr_next = '0;
            qc_next = '0;
            pr_next = '0;
            pc_next = '0;
            qa_next = 1'b0;
            pa_next = 1'b0;
        end
        else if (accept)
        begin
            if (tc_reg == wm1_c)
            begin
                tc_next = '0;
                tr_next = tr_reg + 1'b1;
            end
            else
            begin
                tc_next = tc_reg + 1'b1;
            end
            if (q_now)
            begin
                qa_next = 1'b1;
                if (qc_reg == wm1_c)
                begin
                    qc_next = '0;
                    qr_next = qr_reg + 1'b1;
                end
                else
                begin
                    qc_next = qc_reg + 1'b1;
                end
            end
            if (p_now)
            begin
                pa_next = 1'b1;
                if (pc_reg == wm1_c)
                begin
                    pc_next = '0;
                    pr_next = pr_reg + 1'b1;
                end
                else
                begin
                    pc_next = pc_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= clamp_width(CFG_W'(RESET_WIDTH));
            tr_reg <= '0;
            tc_reg <= '0;
            qr_reg <= '0;
            qc_reg <= '0;
            pr_reg <= '0;
            pc_reg <= '0;
            qa_reg <= 1'b0;
            pa_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                w_reg <= clamp_width(cfg_data);
            end
            tr_reg <= tr_next;
            tc_reg <= tc_next;
            qr_reg <= qr_next;
            qc_reg <= qc_next;
            pr_reg <= pr_next;
            pc_reg <= pc_next;
            qa_reg <= qa_next;
            pa_reg <= pa_next;
        end
    end

    // the sharpen stream never runs ahead of the blur stream
    a_order: assert property (@(posedge clk) disable iff (!rst_n) pa_reg |-> qa_reg)
        else $error("sharpen stream active without blur stream");

    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && wrap |=> (tr_reg == '0) && (tc_reg == '0) && !qa_reg && !pa_reg)
        else $error("frame did not restart after last pixel");

endmodule
`default_nettype wire

/* rtl/bbs_back.sv */
`default_nettype none
module bbs_back
    import bbs_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire bbs_ctl_t          in_ctl,
    input  wire logic [PIX_W-1:0]  in_pix,
    input  wire logic [CW-1:0]     in_tc,
    input  wire logic [CW-1:0]     in_qc,
    output logic                   in_pop,
    input  wire logic              out_full,
    output logic                   out_push,
    output logic      [OUT_W-1:0]  out_data
);
    localparam int STAGES = 10;

    logic adv;

    logic     v_reg   [STAGES];
    bbs_ctl_t ctl_reg [STAGES];
    logic [CW-1:0] qc_reg [STAGES];
    logic [CW-1:0] tc1_reg;

    logic [PIX_W-1:0] pix1_reg, pix2_reg, smid_reg;
    logic [PIX_W-1:0] src_a_rd, src_b_rd, blr_a_rd, blr_b_rd;
    logic [PIX_W-1:0] swin_reg [3][3];
    logic [PIX_W-1:0] bwin_reg [3][3];
    logic [4:0]       d9_reg   [3][3][3];
    logic [PIX_W-1:0] scen_reg, blur5_reg, blur6_reg, blur7_reg, bmid_reg;
    logic [PIX_W-1:0] c9_reg;
    logic [11:0]      nine_reg [3];
    logic [9:0]       sa_reg   [3];
    logic [9:0]       sb_reg   [3];
    logic [PIX_W-1:0] blur_o_reg, sharp_o_reg;
    logic             last_o_reg;

    logic [PIX_W-1:0] blur_sum;
    logic [PIX_W-1:0] sharp_val;

    assign adv    = !out_full;
    assign in_pop = adv && in_valid;

    bbs_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW), .WIDTH(PIX_W)) u_src_a (
        .clk(clk), .en(adv && in_valid), .addr(in_tc), .wdata(in_pix), .rdata(src_a_rd)
    );
    bbs_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW), .WIDTH(PIX_W)) u_src_b (
        .clk(clk), .en(adv && v_reg[0]), .addr(tc1_reg), .wdata(src_a_rd), .rdata(src_b_rd)
    );
    bbs_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW), .WIDTH(PIX_W)) u_blr_a (
        .clk(clk), .en(adv && v_reg[4] && ctl_reg[4].q_act), .addr(qc_reg[4]),
        .wdata(blur5_reg), .rdata(blr_a_rd)
    );
    bbs_line_ram #(.DEPTH(MAX_WIDTH), .AW(CW), .WIDTH(PIX_W)) u_blr_b (
        .clk(clk), .en(adv && v_reg[5] && ctl_reg[5].q_act), .addr(qc_reg[5]),
        .wdata(blr_a_rd), .rdata(blr_b_rd)
    );

    always_comb
    begin
        logic [8:0] s;
        for (int k = 0; k < 3; k++)
        begin
            s = '0;
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    s = s + 9'(d9_reg[c][r][k]);
                end
            end
            blur_sum[k*CHAN_W +: CHAN_W] = s[CHAN_W-1:0];
        end
    end

    always_comb
    begin
        logic signed [12:0] acc;
        for (int k = 0; k < 3; k++)
        begin
            acc = $signed({1'b0, nine_reg[k]}) - $signed({3'b000, sa_reg[k]})
                  - $signed({3'b000, sb_reg[k]});
            if (acc < 0)
            begin
                sharp_val[k*CHAN_W +: CHAN_W] = '0;
            end
            else if (acc > 13'sd255)
            begin
                sharp_val[k*CHAN_W +: CHAN_W] = CHAN_W'(CHAN_MAX);
            end
            else
            begin
                sharp_val[k*CHAN_W +: CHAN_W] = acc[CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < STAGES; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= in_ctl;
            qc_reg[0]  <= in_qc;
            for (int i = 1; i < STAGES; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
                qc_reg[i]  <= qc_reg[i-1];
            end
            tc1_reg   <= in_tc;
            pix1_reg  <= in_pix;
            pix2_reg  <= pix1_reg;
            smid_reg  <= src_a_rd;
            blur6_reg <= blur5_reg;
            blur7_reg <= blur6_reg;
            bmid_reg  <= blr_a_rd;

            // shift a new column into each window
            if (v_reg[1])
            begin
                swin_reg[2] <= swin_reg[1];
                swin_reg[1] <= swin_reg[0];
                swin_reg[0][0] <= src_b_rd;
                swin_reg[0][1] <= smid_reg;
                swin_reg[0][2] <= pix2_reg;
            end
            if (v_reg[6])
            begin
                bwin_reg[2] <= bwin_reg[1];
                bwin_reg[1] <= bwin_reg[0];
                bwin_reg[0][0] <= blr_b_rd;
                bwin_reg[0][1] <= bmid_reg;
                bwin_reg[0][2] <= blur7_reg;
            end

            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        d9_reg[c][r][k] <= div9(swin_reg[c][r][k*CHAN_W +: CHAN_W]);
                    end
                end
            end
            scen_reg  <= swin_reg[1][1];
            blur5_reg <= ctl_reg[3].q_border ? scen_reg : blur_sum;

            c9_reg <= bwin_reg[1][1];
            for (int k = 0; k < 3; k++)
            begin
                nine_reg[k] <= {1'b0, bwin_reg[1][1][k*CHAN_W +: CHAN_W], 3'b000}
                               + 12'(bwin_reg[1][1][k*CHAN_W +: CHAN_W]);
                sa_reg[k] <= 10'(bwin_reg[0][0][k*CHAN_W +: CHAN_W])
                             + 10'(bwin_reg[1][0][k*CHAN_W +: CHAN_W])
                             + 10'(bwin_reg[2][0][k*CHAN_W +: CHAN_W])
                             + 10'(bwin_reg[0][1][k*CHAN_W +: CHAN_W]);
                sb_reg[k] <= 10'(bwin_reg[2][1][k*CHAN_W +: CHAN_W])
                             + 10'(bwin_reg[0][2][k*CHAN_W +: CHAN_W])
                             + 10'(bwin_reg[1][2][k*CHAN_W +: CHAN_W])
                             + 10'(bwin_reg[2][2][k*CHAN_W +: CHAN_W]);
            end

            blur_o_reg  <= c9_reg;
            sharp_o_reg <= ctl_reg[8].p_border ? c9_reg : sharp_val;
            last_o_reg  <= ctl_reg[8].last;
        end
    end

    assign out_push = adv && v_reg[STAGES-1] && ctl_reg[STAGES-1].p_out;
    assign out_data = {last_o_reg, sharp_o_reg, blur_o_reg};

    a_border: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STAGES-1] && ctl_reg[STAGES-1].p_out && ctl_reg[STAGES-1].p_border
        |-> sharp_o_reg == blur_o_reg)
        else $error("border pixel differs between images");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[STAGES-1] && !adv |=> v_reg[STAGES-1] && $stable(sharp_o_reg)
        && $stable(blur_o_reg))
        else $error("result changed while output queue full");

endmodule
`default_nettype wire

/* rtl/box_blur_then_sharpen_3x3.sv */
`default_nettype none
// 3x3 box blur followed by a 3x3 sharpen of the blurred image, RGB, square frame.
// Input queue port: a transaction is taken when push is high and full is low;
// kind 0 carries a raster-order pixel, kind 1 is a flush tick with no pixel.
// Result queue port: the oldest result sits on the outputs while empty is low
// and is taken when pop is high. cfg_write loads image_width (clamped to
// 3..MAX_WIDTH) and restarts the frame; write it only while the block is idle.
// Result for pixel p is produced by the input transaction at frame position
// p + 2*width + 2, so 2*width + 2 flush ticks after the last pixel drain a frame;
// frame_last marks the final pixel. Once that transaction is taken the result
// passes through the middle queue and ten pipeline stages to the result queue.
// Throughput is one transaction per cycle unless the result queue is full, set
// by the read-then-write of the four line RAMs, one per line delay and image.
// Reset zeroes the position counters and empties both queues, and sets width
// to 512; line-buffer contents are not cleared and need not be.
// When pop stays low the output queue fills, the pipeline holds, the input queue
// fills and full rises; nothing is dropped.
module box_blur_then_sharpen_3x3
    import bbs_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              kind,
    input  wire logic [CHAN_W-1:0] pixel_red,
    input  wire logic [CHAN_W-1:0] pixel_green,
    input  wire logic [CHAN_W-1:0] pixel_blue,
    output logic                   empty,
    input  wire logic              pop,
    output logic      [CHAN_W-1:0] blur_red,
    output logic      [CHAN_W-1:0] blur_green,
    output logic      [CHAN_W-1:0] blur_blue,
    output logic      [CHAN_W-1:0] sharp_red,
    output logic      [CHAN_W-1:0] sharp_green,
    output logic      [CHAN_W-1:0] sharp_blue,
    output logic                   frame_last
);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int MIDW = $bits(bbs_ctl_t) + PIX_W + 2 * CW;

    bbs_ctl_t         f_ctl, b_ctl;
    logic             f_push;
    logic [PIX_W-1:0] f_pix, b_pix;
    logic [CW-1:0]    f_tc, f_qc, b_tc, b_qc;
    logic [MIDW-1:0]  mid_wdata, mid_rdata;
    logic             mid_empty, mid_pop;
    logic             o_full, o_push;
    logic [OUT_W-1:0] o_wdata, o_rdata;

    bbs_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_front (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .push(push), .kind(kind), .pix_in({pixel_blue, pixel_green, pixel_red}),
        .q_full(full), .q_push(f_push), .q_ctl(f_ctl), .q_pix(f_pix),
        .q_tc(f_tc), .q_qc(f_qc)
    );

    assign mid_wdata = {f_ctl, f_pix, f_tc, f_qc};
    assign {b_ctl, b_pix, b_tc, b_qc} = mid_rdata;

    bbs_fifo #(.WIDTH(MIDW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
        .clk(clk), .rst_n(rst_n), .wr(f_push), .wdata(mid_wdata), .rd(mid_pop),
        .rdata(mid_rdata), .full(full), .empty(mid_empty)
    );

    bbs_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(!mid_empty), .in_ctl(b_ctl),
        .in_pix(b_pix), .in_tc(b_tc), .in_qc(b_qc), .in_pop(mid_pop),
        .out_full(o_full), .out_push(o_push), .out_data(o_wdata)
    );

    bbs_fifo #(.WIDTH(OUT_W), .DEPTH(QUEUE_DEPTH)) u_out_q (
        .clk(clk), .rst_n(rst_n), .wr(o_push), .wdata(o_wdata), .rd(pop && !empty),
        .rdata(o_rdata), .full(o_full), .empty(empty)
    );

    assign blur_red    = o_rdata[0*CHAN_W +: CHAN_W];
    assign blur_green  = o_rdata[1*CHAN_W +: CHAN_W];
    assign blur_blue   = o_rdata[2*CHAN_W +: CHAN_W];
    assign sharp_red   = o_rdata[PIX_W + 0*CHAN_W +: CHAN_W];
    assign sharp_green = o_rdata[PIX_W + 1*CHAN_W +: CHAN_W];
    assign sharp_blue  = o_rdata[PIX_W + 2*CHAN_W +: CHAN_W];
    assign frame_last  = o_rdata[OUT_W-1];

endmodule
`default_nettype wire

/* verif/box_blur_then_sharpen_3x3_test.sv */
`timescale 1ns / 100ps
`default_nettype none
module box_blur_then_sharpen_3x3_test;
    import bbs_pkg::*;

    localparam int LINE_RING   = 2 * 1024 + 3;
    localparam int DRAIN_WAIT  = 16;
    localparam int ITEM_TARGET = 1300;
    localparam bit KIND_PIXEL  = 1'b0;
    localparam bit KIND_FLUSH  = 1'b1;

    typedef struct {
        logic [CHAN_W-1:0] blur_r, blur_g, blur_b;
        logic [CHAN_W-1:0] sharp_r, sharp_g, sharp_b;
        logic              last;
    } out_pixel_t;

    class blur_sharpen_board;
        logic [PIX_W-1:0] src_ring [LINE_RING];
        logic [PIX_W-1:0] blur_ring [LINE_RING];
        int unsigned      frame_pos;
        logic [CFG_W-1:0] width_reg;
        out_pixel_t       pending_pixels [$];
        int               error_count;
        int               pixels_checked;
        int               frames_done;

        function void clear();
            frame_pos = 0;
            width_reg = CFG_W'(RESET_WIDTH);
            pending_pixels.delete();
        endfunction

        function void set_width(logic [CFG_W-1:0] v);
            width_reg = v;
            frame_pos = 0;
        endfunction

        function int unsigned side();
            if (width_reg < MIN_WIDTH)
                return MIN_WIDTH;
            if (width_reg > 1024)
                return 1024;
            return 32'(width_reg);
        endfunction

        function bit edge_pixel(int unsigned idx, int unsigned w);
            return (idx / w == 0) || (idx % w == 0) || (idx / w == w - 1) || (idx % w == w - 1);
        endfunction

        function logic [PIX_W-1:0] box_mean(int unsigned q, int unsigned w);
            logic [PIX_W-1:0] res;
            int unsigned      sum, idx;
            logic [PIX_W-1:0] px;
            if (edge_pixel(q, w))
                return src_ring[q % LINE_RING];
            for (int k = 0; k < 3; k++)
            begin
                sum = 0;
                for (int dr = 0; dr < 3; dr++)
                    for (int dc = 0; dc < 3; dc++)
                    begin
                        idx = q - w - 1 + dr * w + dc;
                        px  = src_ring[idx % LINE_RING];
                        sum += px[8*k +: 8] / 9;
                    end
                if (sum > CHAN_MAX)
                    sum = CHAN_MAX;
                res[8*k +: 8] = sum[7:0];
            end
            return res;
        endfunction

        function logic [PIX_W-1:0] sharpen(int unsigned p, int unsigned w);
            logic [PIX_W-1:0] res;
            int               acc;
            int unsigned      idx;
            logic [PIX_W-1:0] px;
            if (edge_pixel(p, w))
                return src_ring[p % LINE_RING];
            for (int k = 0; k < 3; k++)
            begin
                acc = 0;
                for (int dr = 0; dr < 3; dr++)
                    for (int dc = 0; dc < 3; dc++)
                    begin
                        idx = p - w - 1 + dr * w + dc;
                        px  = blur_ring[idx % LINE_RING];
                        if (dr == 1 && dc == 1)
                            acc += 9 * int'(px[8*k +: 8]);
                        else
                            acc -= int'(px[8*k +: 8]);
                    end
                if (acc < 0)
                    acc = 0;
                if (acc > CHAN_MAX)
                    acc = CHAN_MAX;
                res[8*k +: 8] = acc[7:0];
            end
            return res;
        endfunction

        // advance the frame by one accepted transaction
        function void take_pixel(bit k, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int unsigned      w, total, t, lag, p;
            logic [PIX_W-1:0] bp, sp;
            out_pixel_t       o;
            w     = side();
            total = w * w;
            t     = frame_pos;
            lag   = 2 * w + 2;
            if (t < total)
                src_ring[t % LINE_RING] = (k == KIND_FLUSH) ? '0 : {b, g, r};
            if (t >= w + 1 && t - w - 1 < total)
                blur_ring[(t - w - 1) % LINE_RING] = box_mean(t - w - 1, w);
            if (t >= lag && t - lag < total)
            begin
                p  = t - lag;
                bp = blur_ring[p % LINE_RING];
                sp = sharpen(p, w);
                o.blur_r  = bp[7:0];
                o.blur_g  = bp[15:8];
                o.blur_b  = bp[23:16];
                o.sharp_r = sp[7:0];
                o.sharp_g = sp[15:8];
                o.sharp_b = sp[23:16];
                o.last    = (p == total - 1);
                pending_pixels.push_back(o);
            end
            frame_pos = t + 1;
            if (frame_pos >= total + lag)
                frame_pos = 0;
        endfunction

        function void match(string name, logic [7:0] exp_v, logic [7:0] act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                error_count++;
            end
        endfunction

        function void check_pixel(out_pixel_t a);
            out_pixel_t e;
            if (pending_pixels.size() == 0)
            begin
                $error("result with no pixel expected");
                error_count++;
                return;
            end
            e = pending_pixels.pop_front();
            match("blur_red", e.blur_r, a.blur_r);
            match("blur_green", e.blur_g, a.blur_g);
            match("blur_blue", e.blur_b, a.blur_b);
            match("sharp_red", e.sharp_r, a.sharp_r);
            match("sharp_green", e.sharp_g, a.sharp_g);
            match("sharp_blue", e.sharp_b, a.sharp_b);
            match("frame_last", 8'(e.last), 8'(a.last));
            pixels_checked++;
            if (a.last)
                frames_done++;
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write = 1'b0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              push = 1'b0;
    logic              full;
    logic              kind = 1'b0;
    logic [CHAN_W-1:0] pixel_red = '0;
    logic [CHAN_W-1:0] pixel_green = '0;
    logic [CHAN_W-1:0] pixel_blue = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [CHAN_W-1:0] blur_red, blur_green, blur_blue;
    logic [CHAN_W-1:0] sharp_red, sharp_green, sharp_blue;
    logic              frame_last;

    blur_sharpen_board board;
    int                items_sent;
    int                widths_used;
    bit                stim_done;

    box_blur_then_sharpen_3x3 i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .empty       (empty),
        .pop         (pop),
        .blur_red    (blur_red),
        .blur_green  (blur_green),
        .blur_blue   (blur_blue),
        .sharp_red   (sharp_red),
        .sharp_green (sharp_green),
        .sharp_blue  (sharp_blue),
        .frame_last  (frame_last)
    );

    always #4 clk = ~clk;

    task automatic send_item(bit k, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        bit quiet;
        quiet = (items_sent >= 500 && items_sent < 800);
        while (!quiet && $urandom_range(99) < 24)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        kind        <= k;
        pixel_red   <= r;
        pixel_green <= g;
        pixel_blue  <= b;
        do
            @(posedge clk);
        while (full);
        board.take_pixel(k, r, g, b);
        items_sent++;
    endtask

    // let the pipeline drain completely, then load a new width
    task automatic write_width(logic [CFG_W-1:0] v);
        push <= 1'b0;
        while (board.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_width(v);
        widths_used++;
    endtask

    function automatic logic [7:0] chan_value(int mode);
        if (mode == 0)
            return 8'($urandom_range(255));
        return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    endfunction

    task automatic send_frame(int unsigned w);
        int mode;
        for (int unsigned i = 0; i < w * w + 2 * w + 2; i++)
        begin
            mode = ($urandom_range(99) < 15) ? 1 : 0;
            if (i >= w * w)
                send_item(1'($urandom_range(1)), chan_value(0), chan_value(0), chan_value(0));
            else if ($urandom_range(99) < 5)
                send_item(KIND_FLUSH, chan_value(0), chan_value(0), chan_value(0));
            else
                send_item(KIND_PIXEL, chan_value(mode), chan_value(mode), chan_value(mode));
        end
    endtask

    initial
    begin
        int unsigned w;
        board = new();
        board.clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // width below range acts as 3: checkerboard, a flush in the frame,
        // mixed pixels and flushes in the drain
        write_width(11'd0);
        for (int i = 0; i < 9; i++)
            if (i == 2)
                send_item(KIND_FLUSH, 8'hFF, 8'hFF, 8'hFF);
            else if (i % 2 == 0)
                send_item(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
            else
                send_item(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        for (int i = 0; i < 8; i++)
            send_item(1'(i % 2), 8'hAA, 8'h55, 8'hFF);

        // magenta on two center pixels over green, width 4, to hit the sharpen clamp both ways
        write_width(11'd4);
        for (int i = 0; i < 26; i++)
            if (i < 16 && (i == 5 || i == 10))
                send_item(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF);
            else
                send_item(i < 16 ? KIND_PIXEL : KIND_FLUSH, 8'h00, 8'hFF, 8'h00);

        // largest widths: no result can come, frame restarts on next write
        write_width(11'h7FF);
        repeat (60) send_item(KIND_PIXEL, chan_value(0), chan_value(0), chan_value(0));
        write_width(11'd1024);
        repeat (60) send_item(1'($urandom_range(1)), chan_value(0), chan_value(0),
                              chan_value(0));

        write_width(11'd3);
        send_frame(3);

        // keep large frames early so the total stays near the target
        while (items_sent < ITEM_TARGET)
        begin
            w = (items_sent < 600 && $urandom_range(99) >= 80) ? $urandom_range(24, 16)
                                                               : $urandom_range(12, 3);
            write_width(11'(w));
            repeat ((items_sent < 1000) ? $urandom_range(2, 1) : 1) send_frame(w);
        end
        push <= 1'b0;
        stim_done = 1'b1;
    end

    // result side: random stalls, one long hold-off, one stretch without stalls
    initial
    begin
        out_pixel_t a;
        bit         held;
        bit         quiet;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && board.pixels_checked >= 150)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (400) @(posedge clk);
            end
            quiet = (board.pixels_checked >= 300 && board.pixels_checked < 600);
            pop <= (quiet || $urandom_range(99) >= 24);
            @(posedge clk);
            if (pop && !empty)
            begin
                a.blur_r  = blur_red;
                a.blur_g  = blur_green;
                a.blur_b  = blur_blue;
                a.sharp_r = sharp_red;
                a.sharp_g = sharp_green;
                a.sharp_b = sharp_blue;
                a.last    = frame_last;
                board.check_pixel(a);
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (board.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT * 2) @(posedge clk);
        $display("Covered %0d transactions over %0d width settings, %0d pixels checked, %0d frames.",
                 items_sent, widths_used, board.pixels_checked, board.frames_done);
        if (board.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("timeout with %0d pixels still expected", board.pending_pixels.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/bbs_pkg.sv
rtl/bbs_fifo.sv
rtl/bbs_line_ram.sv
rtl/bbs_front.sv
rtl/bbs_back.sv
rtl/box_blur_then_sharpen_3x3.sv
verif/box_blur_then_sharpen_3x3_test.sv
